// File: src/bisort_pkg.sv
// types and constants shared by the binary insertion sorter
package bisort_pkg;

    localparam int KEY_W = 32;

    typedef logic signed [KEY_W-1:0] key_t;

    typedef struct packed {
        key_t sort_key;
        logic final_key;
    } in_item_t;

    typedef struct packed {
        key_t sorted_key;
        logic end_of_run;
        logic overflowed;
    } out_item_t;

    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;

    typedef struct packed {
        key_t key;
        logic gt;
        logic occupied;
    } cell_link_t;

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_EMIT = 2'b10
    } sorter_state_t;

endpackage

// File: src/bisort_cell.sv
// one cell of the insertion chain: holds a key, compares, shifts up or down
module bisort_cell
    import bisort_pkg::*;
(
    input  logic       aclk,
    input  cell_ctrl_t ctrl,
    input  key_t       new_key,
    input  logic       occupied,
    input  cell_link_t left,
    input  key_t       right_key,
    output cell_link_t link
);

    key_t key_reg;
    key_t key_next;
    logic gt;

    assign gt            = occupied && (key_reg > new_key);
    assign link.key      = key_reg;
    assign link.gt       = gt;
    assign link.occupied = occupied;

    always_comb begin
        key_next = key_reg;
        priority if (ctrl.shift) begin
            key_next = right_key;
        end else if (ctrl.insert) begin
            priority if (left.gt) begin
                key_next = left.key;
            end else if (left.occupied && (gt || !occupied)) begin
                key_next = new_key;
            end else begin
                key_next = key_reg;
            end
        end else begin
            key_next = key_reg;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

endmodule

// File: src/binary_insertion_sorter_top.sv
// top level of the binary insertion sorter: cell chain, control and output register
//
// s_ channel takes one signed key per transaction, with final_key marking the
// last key of a batch. while loading, a key is taken every cycle and yields no
// result; each key is inserted into a chain of DEPTH cells, equal keys landing
// after those already held. keys beyond DEPTH in a batch are dropped and the
// batch is flagged overflowed.
// after the final transaction is accepted, s_ready is low while the batch is
// emitted on the m_ channel in ascending order, end_of_run on the largest key.
// the first result is registered once the control has entered emission; results
// then follow one per cycle while m_ready stays high, the chain shifting down
// one cell per result.
// if the receiver stalls, the output register holds its transaction and the
// chain stops shifting until m_ready returns.
// reset empties the list, clears the overflow flag and m_valid; there is no
// clearing pass, s_ready is high from the first cycle after reset.
module binary_insertion_sorter_top
    import bisort_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int CW = $clog2(DEPTH + 1);

    sorter_state_t state_reg, state_next;
    logic [CW-1:0] held_count_reg, held_count_next;
    logic          overflow_reg, overflow_next;
    logic          m_valid_reg, m_valid_next;
    out_item_t     m_data_reg, m_data_next;

    cell_ctrl_t    ctrl;
    cell_link_t    links [DEPTH];
    logic          s_accept;
    logic          emit_go;
    logic          has_room;

    assign s_ready  = (state_reg == ST_LOAD);
    assign s_accept = s_valid && s_ready;
    assign has_room = (held_count_reg < CW'(DEPTH));
    assign emit_go  = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    assign ctrl.insert = s_accept && has_room;
    assign ctrl.shift  = emit_go;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        cell_link_t left;
        key_t       right_key;

        if (i == 0) begin : g_first
            assign left.key      = '0;
            assign left.gt       = 1'b0;
            assign left.occupied = 1'b1;
        end else begin : g_mid
            assign left = links[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_key = '0;
        end else begin : g_inner
            assign right_key = links[i+1].key;
        end

        bisort_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .new_key   (s_data.sort_key),
            .occupied  (CW'(i) < held_count_reg),
            .left      (left),
            .right_key (right_key),
            .link      (links[i])
        );
    end

    always_comb begin
        state_next      = state_reg;
        held_count_next = held_count_reg;
        overflow_next   = overflow_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD: begin
                if (s_accept) begin
                    if (has_room) begin
                        held_count_next = held_count_reg + CW'(1);
                    end else begin
                        overflow_next = 1'b1;
                    end
                    if (s_data.final_key) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (emit_go) begin
                    m_valid_next           = 1'b1;
                    m_data_next.sorted_key = links[0].key;
                    m_data_next.end_of_run = (held_count_reg == CW'(1));
                    m_data_next.overflowed = overflow_reg;
                    held_count_next        = held_count_reg - CW'(1);
                    if (held_count_reg == CW'(1)) begin
                        state_next    = ST_LOAD;
                        overflow_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            held_count_reg <= '0;
            overflow_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            held_count_reg <= held_count_next;
            overflow_reg   <= overflow_next;
            m_valid_reg    <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: src/bisort_checker.sv
// port-level checks for the binary insertion sorter, bound to the top level
module bisort_checker
    import bisort_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_final_closes_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.final_key |=> !s_ready)
        else $error("input still open after final transaction");

    a_batch_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.end_of_run |-> !s_ready)
        else $error("input open mid batch");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("wrong state after reset");

endmodule

bind binary_insertion_sorter_top bisort_checker u_bisort_checker (.*);
